[hw/rtl/nms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_pkg
// Shared types and constants of the non-maximum suppression unit.
// ----------------------------------------------------------------------------
package nms_pkg;

   // parameter defaults
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAG_BITS_DEF  = 11;

   // fixed field widths
   localparam int GRAD_W       = 11;
   localparam int REQ_TDATA_W  = 24;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_ADDR_W   = 1;
   localparam int SEC_W        = 2;

   // register reset values
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_IMAGE_WIDTH  = 1'd0,
      REG_IMAGE_HEIGHT = 1'd1
   } csr_reg_type;

   // gradient direction, named after the neighbour pair it compares
   typedef enum logic [SEC_W-1:0] {
      SEC_HORZ      = 2'd0,   // left and right
      SEC_DIAG_DOWN = 2'd1,   // down-right and up-left
      SEC_VERT      = 2'd2,   // up and down
      SEC_DIAG_UP   = 2'd3    // down-left and up-right
   } sector_type;

   // per-pixel control flags carried from front to back
   typedef struct packed {
      logic emit;        // pixel produces a result beat
      logic centre_ok;   // centre is an interior pixel
      logic col_last;    // last column of its row
      logic row_last;    // last row of the frame
   } rec_flags_type;

   // record bits that do not scale with the magnitude width
   localparam int REC_FIXED_W = SEC_W + $bits(rec_flags_type);

endpackage

[hw/rtl/canny_nonmax_suppression_unit.sv]
`timescale 1ns / 1ps
// Path: the beat that completes a 3x3 window (one row and one column later in
// raster order) passes the front stage, record queue, window and result registers.
// Throughput: one pixel per cycle while the receiver takes beats; the pixel
// closing a row is held while the single result register sends the line-end beat.
// Reset: synchronous; counters and pipeline clear, size returns to 640x480,
// line buffers keep their contents.
// ----------------------------------------------------------------------------
// canny_nonmax_suppression_unit
// Canny non-maximum suppression over a 3x3 window of gradient magnitudes.
// ----------------------------------------------------------------------------
module canny_nonmax_suppression_unit import nms_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int MAG_BITS  = MAG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration: index 0 image_width, index 1 image_height
   input  logic                           csr_we,
   input  logic [CSR_ADDR_W-1:0]          csr_addr,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   // gradient beats
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_TDATA_W-1:0]         req_tdata,   // grad_x [10:0], grad_y [21:11]
   // result beats
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [((MAG_BITS+7)/8)*8-1:0]  rsp_tdata,   // edge_magnitude [MAG_BITS-1:0]
   output logic                           rsp_tlast,   // line_end
   output logic                           rsp_tuser    // frame_end
);

   localparam int REC_W = 3 * MAG_BITS + REC_FIXED_W;

   logic             push_valid, push_ready;
   logic [REC_W-1:0] push_data;
   logic             pop_valid, pop_ready;
   logic [REC_W-1:0] pop_data;

   // front: counters, magnitude, sector, line buffers
   nms_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAG_BITS  (MAG_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // record queue between front and back
   nms_fifo #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: window, suppression, result beats
   nms_back #(
      .MAG_BITS (MAG_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[hw/rtl/nms_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/nms_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_fifo
// Small register queue with valid/ready on both sides.
// ----------------------------------------------------------------------------
module nms_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/nms_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_front
// Accepts gradient beats, forms magnitude and sector, keeps the row and
// column counters and the line buffers, and queues one column record a beat.
// ----------------------------------------------------------------------------
module nms_front import nms_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int MAG_BITS  = MAG_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_we,
   input  logic [CSR_ADDR_W-1:0]               csr_addr,
   input  logic [CSR_DATA_W-1:0]               csr_wdata,
   // gradient beats
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_TDATA_W-1:0]              req_tdata,
   // column records
   output logic                                push_valid,
   input  logic                                push_ready,
   output logic [3*MAG_BITS+REC_FIXED_W-1:0]   push_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CMP_W  = ((COL_W > WIDTH_REG_W) ? COL_W : WIDTH_REG_W) + 1;
   localparam int SUM_W  = GRAD_W + 1;
   localparam int EXT_W  = (SUM_W > MAG_BITS) ? SUM_W : MAG_BITS;
   localparam int RAM_W  = 2 * MAG_BITS + SEC_W;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [HEIGHT_REG_W-1:0] row_ff, row_in;

   logic                    a_valid_ff;
   logic [MAG_BITS-1:0]     a_mag_ff;
   sector_type              a_sec_ff;
   logic [COL_W-1:0]        a_col_ff;
   rec_flags_type           a_flags_ff;

   logic                    accept, push;
   logic signed [GRAD_W-1:0] gx, gy;
   logic signed [GRAD_W:0]  gx_w, gy_w, fx, fy;
   logic [GRAD_W-1:0]       ax, ay;
   logic [EXT_W-1:0]        sum_ext;
   logic [MAG_BITS-1:0]     mag;
   sector_type              sec;
   logic                    flip;

   logic [CMP_W-1:0]        w_eff, w_last, col_ext;
   logic [HEIGHT_REG_W-1:0] h_last;
   rec_flags_type           flags;

   logic [RAM_W-1:0]        ram_rd, ram_wr;
   logic [MAG_BITS-1:0]     rd_old_mag, rd_mid_mag;
   logic [SEC_W-1:0]        rd_mid_sec;

   // handshake: stage holds one beat until the queue takes its record
   assign push       = a_valid_ff && push_ready;
   assign req_tready = !a_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(WIDTH_RESET);
         height_ff <= HEIGHT_REG_W'(HEIGHT_RESET);
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // magnitude |gx|+|gy|, saturated
   assign gx      = req_tdata[GRAD_W-1:0];
   assign gy      = req_tdata[2*GRAD_W-1:GRAD_W];
   assign gx_w    = (GRAD_W+1)'(gx);
   assign gy_w    = (GRAD_W+1)'(gy);
   assign ax      = gx[GRAD_W-1] ? GRAD_W'(-gx_w) : GRAD_W'(gx_w);
   assign ay      = gy[GRAD_W-1] ? GRAD_W'(-gy_w) : GRAD_W'(gy_w);
   assign sum_ext = EXT_W'(SUM_W'(ax) + SUM_W'(ay));
   assign mag     = (sum_ext > EXT_W'((1 << MAG_BITS) - 1)) ? {MAG_BITS{1'b1}}
                                                           : sum_ext[MAG_BITS-1:0];

   // sector: fold into the upper half plane, then compare |gy| with |gx|
   always_comb begin
      flip = (gy < 0) || ((gy == 0) && (gx < 0));
      fx   = flip ? -gx_w : gx_w;
      fy   = flip ? -gy_w : gy_w;
      if (fy == 0) begin
         sec = SEC_HORZ;
      end else if (fx > 0) begin
         sec = (fy < fx) ? SEC_HORZ : SEC_DIAG_DOWN;
      end else if (fx == 0) begin
         sec = SEC_VERT;
      end else begin
         sec = (fy > -fx) ? SEC_VERT : SEC_DIAG_UP;
      end
   end

   // position flags from the clamped frame size
   always_comb begin
      w_eff = CMP_W'(width_ff);
      if (w_eff < CMP_W'(3)) begin
         w_eff = CMP_W'(3);
      end else if (w_eff > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end
      w_last  = w_eff - 1'b1;
      h_last  = (height_ff < HEIGHT_REG_W'(3)) ? HEIGHT_REG_W'(2) : height_ff - 1'b1;
      col_ext = CMP_W'(col_ff);
      flags.col_last  = (col_ext >= w_last);
      flags.row_last  = (row_ff >= h_last);
      flags.emit      = (row_ff != '0) && (col_ff != '0);
      flags.centre_ok = (row_ff >= HEIGHT_REG_W'(2)) && (col_ext >= CMP_W'(2))
                        && (col_ext <= w_last);
   end

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags.col_last) begin
            col_in = '0;
            row_in = flags.row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (push) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   // beat held while the line buffer read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         a_mag_ff   <= mag;
         a_sec_ff   <= sec;
         a_col_ff   <= col_ff;
         a_flags_ff <= flags;
      end
   end

   // line buffers: {middle sector, middle magnitude, older magnitude}
   assign rd_old_mag = ram_rd[MAG_BITS-1:0];
   assign rd_mid_mag = ram_rd[2*MAG_BITS-1:MAG_BITS];
   assign rd_mid_sec = ram_rd[RAM_W-1:2*MAG_BITS];
   assign ram_wr     = {a_sec_ff, a_mag_ff, rd_mid_mag};

   nms_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (a_col_ff),
      .wr_data (ram_wr),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd)
   );

   // column record: {flags, middle sector, bottom, middle, top}
   assign push_valid = a_valid_ff;
   assign push_data  = {a_flags_ff, rd_mid_sec, a_mag_ff, rd_mid_mag, rd_old_mag};

endmodule

[hw/rtl/nms_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_back
// Shifts column records into the 3x3 window, suppresses non-maxima and
// drives result beats, adding the zero line-end beat at each row end.
// ----------------------------------------------------------------------------
module nms_back import nms_pkg::*; #(
   parameter int MAG_BITS = MAG_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // column records
   input  logic                                      pop_valid,
   output logic                                      pop_ready,
   input  logic [3*MAG_BITS+REC_FIXED_W-1:0]         pop_data,
   // result beats
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((MAG_BITS+7)/8)*8-1:0]             rsp_tdata,
   output logic                                      rsp_tlast,
   output logic                                      rsp_tuser
);

   localparam int RSP_TDATA_W = ((MAG_BITS + 7) / 8) * 8;

   typedef enum logic {
      PH_RESULT,
      PH_LINE_END
   } phase_type;

   phase_type           phase_ff;
   logic [MAG_BITS-1:0] win_ff [3][3];
   sector_type          wsec_ff [2];
   logic                w_valid_ff;
   rec_flags_type       w_flags_ff;
   logic                rsp_valid_ff;
   logic [MAG_BITS-1:0] rsp_mag_ff;
   logic                rsp_last_ff;
   logic                rsp_user_ff;

   logic [MAG_BITS-1:0] top, mid, bot;
   sector_type          rec_sec;
   rec_flags_type       rec_flags;
   logic                out_free, out_load, w_done, pop;
   logic [MAG_BITS-1:0] centre, v1, v2, kept;

   // record unpacking
   assign top       = pop_data[MAG_BITS-1:0];
   assign mid       = pop_data[2*MAG_BITS-1:MAG_BITS];
   assign bot       = pop_data[3*MAG_BITS-1:2*MAG_BITS];
   assign rec_sec   = sector_type'(pop_data[3*MAG_BITS+SEC_W-1:3*MAG_BITS]);
   assign rec_flags = rec_flags_type'(pop_data[3*MAG_BITS+REC_FIXED_W-1:3*MAG_BITS+SEC_W]);

   // stage handshake
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign out_load  = w_valid_ff && w_flags_ff.emit && out_free;
   assign w_done    = w_valid_ff && (!w_flags_ff.emit
                      || (out_load && ((phase_ff == PH_LINE_END) || !w_flags_ff.col_last)));
   assign pop_ready = !w_valid_ff || w_done;
   assign pop       = pop_valid && pop_ready;

   // neighbour selection along the centre's sector
   always_comb begin
      centre = win_ff[1][1];
      case (wsec_ff[0])
         SEC_HORZ: begin
            v1 = win_ff[1][0];
            v2 = win_ff[1][2];
         end
         SEC_DIAG_DOWN: begin
            v1 = win_ff[2][2];
            v2 = win_ff[0][0];
         end
         SEC_VERT: begin
            v1 = win_ff[0][1];
            v2 = win_ff[2][1];
         end
         default: begin
            v1 = win_ff[2][0];
            v2 = win_ff[0][2];
         end
      endcase
      kept = (w_flags_ff.centre_ok && (centre > v1) && (centre > v2)) ? centre : '0;
   end

   // window shift, one column per record
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= top;
         win_ff[1][2] <= mid;
         win_ff[2][2] <= bot;
         wsec_ff[0]   <= wsec_ff[1];
         wsec_ff[1]   <= rec_sec;
         w_flags_ff   <= rec_flags;
      end
   end

   // phase and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RESULT;
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            w_valid_ff <= 1'b1;
         end else if (w_done) begin
            w_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= ((phase_ff == PH_RESULT) && w_flags_ff.col_last) ? PH_LINE_END
                                                                          : PH_RESULT;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (out_load) begin
         if (phase_ff == PH_LINE_END) begin
            rsp_mag_ff  <= '0;
            rsp_last_ff <= 1'b1;
            rsp_user_ff <= w_flags_ff.row_last;
         end else begin
            rsp_mag_ff  <= kept;
            rsp_last_ff <= 1'b0;
            rsp_user_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_mag_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[test/canny_nonmax_suppression_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canny_nonmax_suppression_unit_test
// Self-checking bench for the non-maximum suppression unit. Gradient frames of
// many sizes stream in with random gaps and backpressure. A bit-accurate
// suppression predictor builds the expected edge beats, and a monitor checks
// every result beat in order, field by field.
// ----------------------------------------------------------------------------
module canny_nonmax_suppression_unit_test;
   import nms_pkg::*;

   localparam int MAG_W          = MAG_BITS_DEF;
   localparam int MAG_LIMIT      = (1 << MAG_W) - 1;
   localparam int LINE_MAX       = MAX_WIDTH_DEF;
   localparam int RSP_W          = ((MAG_W + 7) / 8) * 8;
   localparam int SETTLE_CYCLES  = 16;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_PIXELS  = 300;
   localparam int DIRECTED_COUNT = 20;

   // content styles of a generated frame
   typedef enum int {
      FILL_FULL,     // any 11-bit gradient pair
      FILL_SMALL,    // small values, many ties and zeros
      FILL_SPARSE    // mostly zero with scattered spikes
   } fill_type;

   typedef struct packed {
      logic [GRAD_W-1:0] grad_y;
      logic [GRAD_W-1:0] grad_x;
   } gradient_type;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic             line_end;
      logic             frame_end;
   } edge_beat_type;

   // dut ports
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // grad_x [10:0], grad_y [21:11]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;         // edge_magnitude [10:0]
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   // directed gradients: extremes, every sector, ties, zero, saturation
   int directed_gx [DIRECTED_COUNT] = '{0, 1023, -1024, 1020, -1020, 0, 0, -1020,
      1020, -1020, 5, 3, -3, -5, -5, -3, 3, 5, 1023, -1};
   int directed_gy [DIRECTED_COUNT] = '{0, 0, -1024, 1020, 1020, 1020, -1020, 0,
      -1020, -1020, 3, 5, 5, 3, -3, -5, -5, -3, 1023, 0};

   // suppression predictor state
   bit [MAG_W-1:0]        older_mag  [LINE_MAX];
   bit [MAG_W-1:0]        middle_mag [LINE_MAX];
   bit [SEC_W-1:0]        middle_sec [LINE_MAX];
   bit [MAG_W-1:0]        win [3][3];
   bit [SEC_W-1:0]        sec_win [2];
   int                    col_cnt    = 0;
   bit [HEIGHT_REG_W-1:0] row_cnt    = '0;
   bit [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_REG_W'(WIDTH_RESET);
   bit [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_REG_W'(HEIGHT_RESET);

   gradient_type  pending_gradients [$];
   edge_beat_type expected_edges [$];
   gradient_type  next_gradient;
   edge_beat_type seen_beat;
   edge_beat_type want_beat;

   // traffic control and statistics
   bit driver_gaps_on = 1'b1;
   bit sink_stalls_on = 1'b1;
   int hold_requests  = 0;
   int holds_served   = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   int pixels_accepted = 0;
   int beats_checked   = 0;
   int kept_edges      = 0;
   int frames_closed   = 0;
   int mismatches      = 0;

   canny_nonmax_suppression_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // gradient direction from signs and |gy| against |gx|, ties go to the diagonal
   function automatic sector_type grad_sector(int gx, int gy);
      if (gy < 0 || (gy == 0 && gx < 0)) begin
         gx = -gx;
         gy = -gy;
      end
      if (gy == 0) return SEC_HORZ;
      if (gx > 0) return (gy < gx) ? SEC_HORZ : SEC_DIAG_DOWN;
      if (gx == 0) return SEC_VERT;
      return (gy > -gx) ? SEC_VERT : SEC_DIAG_UP;
   endfunction

   // advance the window by one pixel and queue the edge beats it releases
   task automatic predict_pixel(gradient_type g);
      int gx, gy, mag, w, h, c, r;
      bit col_last, row_last;
      bit [MAG_W-1:0] side_a, side_b, kept;
      gx = int'($signed(g.grad_x));
      gy = int'($signed(g.grad_y));
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;
      w = int'(cfg_width);
      h = int'(cfg_height);
      if (w < 3) w = 3;
      if (w > LINE_MAX) w = LINE_MAX;
      if (h < 3) h = 3;
      c = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
      r = int'(row_cnt);
      col_last = (c >= w - 1);
      row_last = (r >= h - 1);

      // shift the window left, new column from the line buffers
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = older_mag[c];
      win[1][2] = middle_mag[c];
      win[2][2] = MAG_W'(mag);
      sec_win[0] = sec_win[1];
      sec_win[1] = middle_sec[c];
      older_mag[c]  = middle_mag[c];
      middle_mag[c] = MAG_W'(mag);
      middle_sec[c] = grad_sector(gx, gy);

      // delayed centre, zero on the border or when not a strict maximum
      if (r >= 1 && c >= 1) begin
         kept = '0;
         if (r >= 2 && c - 1 >= 1 && c - 1 <= w - 2) begin
            side_a = '0;
            side_b = '0;
            case (sector_type'(sec_win[0]))
               SEC_HORZ: begin
                  side_a = win[1][0];
                  side_b = win[1][2];
               end
               SEC_DIAG_DOWN: begin
                  side_a = win[2][2];
                  side_b = win[0][0];
               end
               SEC_VERT: begin
                  side_a = win[0][1];
                  side_b = win[2][1];
               end
               default: begin
                  side_a = win[2][0];
                  side_b = win[0][2];
               end
            endcase
            if (win[1][1] > side_a && win[1][1] > side_b) kept = win[1][1];
         end
         expected_edges.push_back(edge_beat_type'{kept, 1'b0, 1'b0});
         if (col_last) expected_edges.push_back(edge_beat_type'{'0, 1'b1, row_last});
      end

      // raster counters, a counter past its last index wraps
      if (col_last) begin
         col_cnt = 0;
         row_cnt = row_last ? '0 : row_cnt + 1'b1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   function automatic gradient_type draw_gradient(fill_type fill);
      gradient_type g;
      g.grad_x = GRAD_W'($urandom);
      g.grad_y = GRAD_W'($urandom);
      case (fill)
         FILL_SMALL: begin
            g.grad_x = GRAD_W'($urandom_range(0, 16) - 8);
            g.grad_y = GRAD_W'($urandom_range(0, 16) - 8);
         end
         FILL_SPARSE: begin
            if ($urandom_range(0, 9) != 0) g = '0;
         end
         default: begin
         end
      endcase
      return g;
   endfunction

   task automatic queue_pixels(int count, fill_type fill);
      repeat (count) pending_gradients.push_back(draw_gradient(fill));
   endtask

   function automatic int draw_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!driver_gaps_on || p < 65) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int draw_stall();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR %s", msg);
   endfunction

   // sender pauses until every expected beat is back, then lets the pipe settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_gradients.size() != 0 || req_tvalid || expected_edges.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_reg_type index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_IMAGE_WIDTH) cfg_width = value[WIDTH_REG_W-1:0];
      else cfg_height = value[HEIGHT_REG_W-1:0];
   endtask

   // clock
   initial begin : clock_gen
      forever #10 clock = ~clock;
   end

   // gradient driver, one beat per free slot with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pixel(gradient_type'(req_tdata[2*GRAD_W-1:0]));
            pixels_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_gradients.size() != 0) begin
               next_gradient = pending_gradients.pop_front();
               req_tdata  <= {{(REQ_TDATA_W - 2*GRAD_W){1'b0}}, next_gradient};
               req_tvalid <= 1'b1;
               gap_left = draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_beat = edge_beat_type'{rsp_tdata[MAG_W-1:0], rsp_tlast, rsp_tuser};
            beats_checked++;
            if (seen_beat.magnitude != 0) kept_edges++;
            if (seen_beat.frame_end) frames_closed++;
            if (expected_edges.size() == 0) begin
               note_failure($sformatf("beat %0d unexpected: mag %0d line_end %0b frame_end %0b",
                  beats_checked, seen_beat.magnitude, seen_beat.line_end, seen_beat.frame_end));
            end else begin
               want_beat = expected_edges.pop_front();
               if (seen_beat !== want_beat)
                  note_failure($sformatf({"beat %0d: expected mag %0d line_end %0b frame_end %0b,",
                     " got mag %0d line_end %0b frame_end %0b"}, beats_checked,
                     want_beat.magnitude, want_beat.line_end, want_beat.frame_end,
                     seen_beat.magnitude, seen_beat.line_end, seen_beat.frame_end));
            end
         end
         // a requested long hold takes over from the random stalls
         if (holds_served < hold_requests) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (sink_stalls_on) stall_left = draw_stall();
         end
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int w, h, random_pixels;
      fill_type fill;
      bit failed;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset width: one 640-wide row, then a 3-wide size with the height
      // below its floor closes the frame two rows later
      queue_pixels(WIDTH_RESET, FILL_FULL);
      wait_idle();
      write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(3));
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_W'(0));
      queue_pixels(2 * 3, FILL_FULL);
      wait_idle();

      // directed 5x4 frame
      write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(5));
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_W'(4));
      foreach (directed_gx[i])
         pending_gradients.push_back(gradient_type'{GRAD_W'(directed_gy[i]),
            GRAD_W'(directed_gx[i])});
      wait_idle();

      // tallest height, then cut short mid-frame: the current row becomes last
      write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(6));
      write_register(REG_IMAGE_HEIGHT, 16'hFFFF);
      queue_pixels(5 * 6, FILL_SMALL);
      wait_idle();
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_W'(3));
      queue_pixels(6, FILL_SMALL);
      wait_idle();

      // width drops below its floor mid-row: the current column closes the row
      write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(10));
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_W'(6));
      queue_pixels(4 * 10 + 7, FILL_FULL);
      wait_idle();
      write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(2));
      queue_pixels(1 + 3, FILL_FULL);
      wait_idle();

      // long receiver hold while the sender streams back to back
      write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(12));
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_W'(6));
      driver_gaps_on = 1'b0;
      hold_requests++;
      queue_pixels(12 * 6, FILL_FULL);
      wait_idle();

      // random frames, some back to back with the same size
      random_pixels = 0;
      w = 12;
      h = 6;
      while (random_pixels < RANDOM_PIXELS) begin
         if ($urandom_range(0, 1) == 0) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 6);
            wait_idle();
            write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
            write_register(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
         end else begin
            while (pending_gradients.size() != 0) @(negedge clock);
         end
         driver_gaps_on = ($urandom_range(0, 3) != 0);
         sink_stalls_on = ($urandom_range(0, 3) != 0);
         fill = fill_type'($urandom_range(0, 2));
         queue_pixels(w * h, fill);
         random_pixels += w * h;
      end
      wait_idle();

      failed = (mismatches != 0) || (expected_edges.size() != 0);
      $display("run covered %0d gradient beats and %0d result beats (%0d kept, %0d frame ends)",
         pixels_accepted, beats_checked, kept_edges, frames_closed);
      $display("widths 3 to %0d, heights up to 65535, mid-frame resizes, %0d-cycle hold",
         WIDTH_RESET, LONG_HOLD);
      if (!failed) begin
         $display("PASS canny_nonmax_suppression_unit");
      end else begin
         $display("FAIL canny_nonmax_suppression_unit");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #100_000_000;
      $display("FAIL canny_nonmax_suppression_unit");
      $finish;
   end

endmodule
